// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Default queue capacity
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned FillW  = 5;

  // Request operation
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_e;

  // Result status
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  // One request as it enters the store
  typedef struct packed {
    spq_cmd_e                 cmd;
    logic signed [ValueW-1:0] item_value;
    logic signed [PrioW-1:0]  item_priority;
  } spq_req_t;

  // One result as it leaves the store
  typedef struct packed {
    spq_status_e              status;
    logic signed [ValueW-1:0] out_value;
    logic [FillW-1:0]         fill_count;
  } spq_res_t;

endpackage : spq_pkg

`default_nettype wire

// ===== sv/spq_store.sv =====
// Sorted entry array with parallel compare and single-step shift.
`default_nettype none

module spq_store #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire spq_pkg::spq_req_t req_i,
  output spq_pkg::spq_res_t      res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Entry array, head at slot 0, no reset: only slots below the count are read
  logic signed [spq_pkg::ValueW-1:0] val_q [DEPTH];
  logic signed [spq_pkg::ValueW-1:0] val_d [DEPTH];
  logic signed [spq_pkg::PrioW-1:0]  pri_q [DEPTH];
  logic signed [spq_pkg::PrioW-1:0]  pri_d [DEPTH];
  logic [CntW-1:0]                   count_q;
  logic [CntW-1:0]                   count_d;

  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ins_here;
  logic             empty;
  logic             full;
  logic             do_insert;
  logic             do_remove;
  logic [CntW+spq_pkg::FillW-1:0] fill_ext;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CntW'(DEPTH));
  assign do_insert = req_valid_i && (req_i.cmd == spq_pkg::CMD_INSERT) && !full;
  assign do_remove = req_valid_i && (req_i.cmd == spq_pkg::CMD_REMOVE) && !empty;

  // Per-slot compare and next value
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    // Occupied slot whose priority is not below the new one: stays put
    assign ge[i] = (CntW'(i) < count_q) && (pri_q[i] >= req_i.item_priority);

    // The new pair lands at the first slot that does not stay put
    if (i == 0) begin : g_head
      assign ins_here[i] = !ge[i];
    end else begin : g_body
      assign ins_here[i] = !ge[i] && ge[i-1];
    end

    always_comb begin
      val_d[i] = val_q[i];
      pri_d[i] = pri_q[i];
      if (do_insert && !ge[i]) begin
        if (ins_here[i]) begin
          val_d[i] = req_i.item_value;
          pri_d[i] = req_i.item_priority;
        end else if (i > 0) begin
          val_d[i] = val_q[(i > 0) ? i - 1 : 0];
          pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_remove && (i < DEPTH - 1)) begin
        val_d[i] = val_q[(i < DEPTH - 1) ? i + 1 : i];
        pri_d[i] = pri_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Next count
  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (do_remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Result for the current request
  assign fill_ext = {{spq_pkg::FillW{1'b0}}, count_d};

  always_comb begin
    res_o.fill_count = fill_ext[spq_pkg::FillW-1:0];
    res_o.out_value  = '0;
    unique case (req_i.cmd)
      spq_pkg::CMD_INSERT: begin
        res_o.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end
      spq_pkg::CMD_REMOVE: begin
        if (empty) begin
          res_o.status    = spq_pkg::ST_EMPTY;
          res_o.out_value = '1;
        end else begin
          res_o.status    = spq_pkg::ST_REMOVED;
          res_o.out_value = val_q[0];
        end
      end
      default: begin
        res_o.status = spq_pkg::ST_FULL;
      end
    endcase
  end

  // Hold the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Shift the entries
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) begin
      val_q[k] <= val_d[k];
      pri_q[k] <= pri_d[k];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_remove |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove did not shrink the count");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (pri_q[0] >= pri_q[1]))
    else $error("head entries out of priority order");

endmodule : spq_store

`default_nettype wire

// ===== sv/spq_out_stage.sv =====
// Result register between the store and the output stream.
`default_nettype none

module spq_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire spq_pkg::spq_res_t res_i,
  input  wire logic              ready_i,
  output logic                   valid_o,
  output logic                   free_o,
  output spq_pkg::spq_res_t      res_o
);

  logic              valid_q;
  spq_pkg::spq_res_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && free_o) |=> valid_q)
    else $error("loaded result not marked valid");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(res_q)))
    else $error("stalled result changed");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ready_i && !load_i) |=> !valid_q)
    else $error("taken result not dropped");

endmodule : spq_out_stage

`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue with stream ports.
//
//  Channel  Dir  Group   Contents
//  request  in   s_axis  tuser: cmd; tdata: item_value, item_priority
//  result   out  m_axis  tuser: status; tdata: out_value, fill_count
//
// One request is taken per cycle unless the result register is stalled; its
// result is registered and appears the next cycle. The work is a parallel
// compare of every slot against the new priority and a one-slot shift of
// the entry row, set by the slot count. Reset clears the entry count and the
// result valid flag; no clearing pass. A stalled result holds the request side
// only while the result register is full and not taken.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [31:0] item_value, [47:32] item_priority
  input  wire logic        s_axis_tuser,  // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] out_value, [36:32] fill_count
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  spq_pkg::spq_req_t req;
  spq_pkg::spq_res_t res_new;
  spq_pkg::spq_res_t res_out;
  logic              accept;
  logic              out_free;

  // Unpack the request
  assign req.cmd           = spq_pkg::spq_cmd_e'(s_axis_tuser);
  assign req.item_value    = s_axis_tdata[31:0];
  assign req.item_priority = s_axis_tdata[47:32];

  assign s_axis_tready = out_free;
  assign accept        = s_axis_tvalid && out_free;

  spq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (req),
    .res_o       (res_new)
  );

  spq_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_new),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (out_free),
    .res_o   (res_out)
  );

  // Pack the result
  assign m_axis_tdata = {3'd0, res_out.fill_count, res_out.out_value};
  assign m_axis_tuser = res_out.status;

endmodule : sorted_priority_queue_unit

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted priority queue stream unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QDEPTH     = 16;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned RAND_COUNT = 950;

  // Expected-result tracker: mirrors the queue contents and checks each result
  class queue_tracker;
    logic [31:0]        slot_value [QDEPTH];
    logic signed [15:0] slot_prio  [QDEPTH];
    int unsigned        fill;
    spq_pkg::spq_res_t  due_results [$];
    int unsigned        n_errors;

    function new();
      fill     = 0;
      n_errors = 0;
    endfunction

    // Apply one accepted request to the mirrored queue and queue its result
    function void note_request(spq_pkg::spq_cmd_e op, logic [31:0] val,
                               logic signed [15:0] prio);
      spq_pkg::spq_res_t res;
      int unsigned       pos;
      res.out_value = '0;
      if (op == spq_pkg::CMD_INSERT) begin
        if (fill >= QDEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // place behind every entry of greater or equal priority
          pos = 0;
          while (pos < fill && slot_prio[pos] >= prio) pos++;
          for (int unsigned i = fill; i > pos; i--) begin
            slot_value[i] = slot_value[i-1];
            slot_prio[i]  = slot_prio[i-1];
          end
          slot_value[pos] = val;
          slot_prio[pos]  = prio;
          fill++;
          res.status = spq_pkg::ST_INSERTED;
        end
      end else begin
        if (fill == 0) begin
          res.status    = spq_pkg::ST_EMPTY;
          res.out_value = '1;
        end else begin
          // pop the head and close the gap
          res.out_value = slot_value[0];
          for (int unsigned i = 1; i < fill; i++) begin
            slot_value[i-1] = slot_value[i];
            slot_prio[i-1]  = slot_prio[i];
          end
          fill--;
          res.status = spq_pkg::ST_REMOVED;
        end
      end
      res.fill_count = fill[4:0];
      due_results.push_back(res);
    endfunction

    // Compare one delivered result with the oldest expectation
    function void check_result(spq_pkg::spq_res_t got);
      spq_pkg::spq_res_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d fill %0d",
               got.status, got.out_value, got.fill_count);
        n_errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        n_errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        n_errors++;
      end
    endfunction

    function bit drained();
      return due_results.size() == 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [31:0] item_value, [47:32] item_priority
  logic        s_axis_tuser = 1'b0; // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] out_value, [36:32] fill_count
  logic [1:0]  m_axis_tuser;        // [1:0] status

  queue_tracker tracker = new();
  int unsigned  n_sent = 0;
  int unsigned  n_got  = 0;

  sorted_priority_queue_unit #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Offer one request, idling at random beforehand, and wait for acceptance
  task automatic send_request(spq_pkg::spq_cmd_e op, logic [31:0] val, logic [15:0] prio);
    bit may_idle;
    may_idle = !(n_sent >= 500 && n_sent < 700);
    while (may_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, val};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(op, val, prio);
    n_sent++;
  endtask

  // Remove request with random don't-care fields
  task automatic send_remove();
    send_request(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
  endtask

  // Pick a priority: plenty of ties and extremes, some fully random
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(3));
      2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return -16'($urandom_range(4, 1));
    endcase
  endfunction

  // Sink side: random stalls, one long hold-off, and a stall-free stretch
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_once && n_sent >= 300) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (n_got >= 500 && n_got < 700) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 12);
      end
    end
  end

  // Check every delivered result
  always @(posedge clk_i) begin
    spq_pkg::spq_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = spq_pkg::spq_status_e'(m_axis_tuser);
      got.out_value  = m_axis_tdata[31:0];
      got.fill_count = m_axis_tdata[36:32];
      tracker.check_result(got);
      n_got++;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned seg_left;
    int unsigned insert_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove from empty, extremes, ties, fill to full, refuse, drain a few
    send_remove();
    send_request(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h7FFF);
    send_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h8000);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, 16'h7FFF);
    send_request(spq_pkg::CMD_INSERT, 32'h0000_0003, 16'h8000);
    for (int k = 0; k < 9; k++) begin
      send_request(spq_pkg::CMD_INSERT, 32'(100 + k), 16'(k % 3));
    end
    send_request(spq_pkg::CMD_INSERT, 32'h5555_AAAA, 16'h7FFF);
    repeat (5) send_remove();

    // Random: segments biased toward filling, balance or draining
    seg_left   = 0;
    insert_pct = 50;
    for (int n = 0; n < RAND_COUNT; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
      end
      seg_left--;
      if ($urandom_range(99) < insert_pct) begin
        send_request(spq_pkg::CMD_INSERT, $urandom, pick_priority());
      end else begin
        send_remove();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results drain, then allow for the result register
    while (!tracker.drained()) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.n_errors == 0 && tracker.drained()) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
